>>> sv/tfcg_pkg.sv
// shared constants for the tempo-following clock generator
package tfcg_pkg;

	localparam int OP_W  = 3;
	localparam int SB_W  = 8;
	localparam int LEN_W = 4;
	localparam int BP_W  = 32;
	localparam int IV_W  = 38;
	localparam int MIN_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_SEND       = 3'd0;
	localparam logic [OP_W-1:0] OP_BEAT_SCHED = 3'd1;
	localparam logic [OP_W-1:0] OP_BEAT_FIRED = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK       = 3'd3;
	localparam logic [OP_W-1:0] OP_RESET      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LINK_READY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd1;

	localparam logic [SB_W-1:0] SB_START    = 8'hFA;
	localparam logic [SB_W-1:0] SB_CONTINUE = 8'hFB;
	localparam logic [SB_W-1:0] SB_STOP     = 8'hFC;
	localparam logic [SB_W-1:0] SB_CLOCK    = 8'hF8;

	localparam int MAX_MSG_LEN         = 8;
	localparam int PULSES_PER_QUARTER  = 24;
	localparam int MIN_INTERVAL_RESET  = 500;
	localparam int US_PER_MS           = 1000;
	localparam int US_PER_MS_W         = 10;

endpackage

>>> sv/tempo_following_clock_generator.sv
// top level: 24-per-quarter clock pulse generator that follows the beat tempo
// the result of an accepted request is registered and held in an output register
// throughput: one request per cycle unless the output is held; a beat-fired request stalls
// after each tempo change while the interval period*1000/pulses is worked out
// the division runs as three 14-bit digit steps, each a reciprocal multiply by the constant
// arst_n clears running, tempo history, timer and output valid; min interval resets to 500
module tempo_following_clock_generator #(
	parameter int PULSES_PER_QUARTER = tfcg_pkg::PULSES_PER_QUARTER
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tfcg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tfcg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tfcg_pkg::OP_W-1:0]        op,
	input  logic [tfcg_pkg::SB_W-1:0]        status_byte,
	input  logic [tfcg_pkg::LEN_W-1:0]       msg_length,
	input  logic [tfcg_pkg::BP_W-1:0]        time_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             send_status,
	output logic                             clock_pulse,
	output logic                             running,
	output logic [tfcg_pkg::BP_W-1:0]        tempo_period_ms,
	output logic [tfcg_pkg::IV_W-1:0]        pulse_interval_us
);

	localparam int BP_W   = tfcg_pkg::BP_W;
	localparam int IV_W   = tfcg_pkg::IV_W;
	localparam int NUM_W  = BP_W + tfcg_pkg::US_PER_MS_W;
	localparam int DIG_W  = 14;
	localparam int STEPS  = NUM_W / DIG_W;
	localparam int STEP_W = $clog2(STEPS);
	localparam int REM_W  = $clog2(PULSES_PER_QUARTER + 1);
	localparam int X_W    = REM_W + DIG_W;
	localparam int SHIFT  = X_W + $clog2(PULSES_PER_QUARTER);
	localparam int RCP_W  = X_W + 1;
	localparam int PROD_W = X_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((longint'(1) << SHIFT)
		+ longint'(PULSES_PER_QUARTER) - 1) / longint'(PULSES_PER_QUARTER));
	localparam logic [NUM_W-1:0] IV_MAX = NUM_W'({IV_W{1'b1}});

	// configuration
	logic                       link_ready_q;
	logic [tfcg_pkg::MIN_W-1:0] min_interval_q;

	// clock state
	logic            run_q, run_d;
	logic [BP_W-1:0] last_target_q, last_target_d;
	logic [BP_W-1:0] beat_period_q, beat_period_d;
	logic            armed_q, armed_d;
	logic [IV_W-1:0] interval_q, interval_d;
	logic [IV_W-1:0] elapsed_q, elapsed_d;
	logic            bp_wr;
	logic            status_d, pulse_d;

	// interval divider
	logic              div_busy_q;
	logic [NUM_W-1:0]  div_num_q;
	logic [REM_W-1:0]  div_rem_q;
	logic [STEP_W-1:0] div_step_q;
	logic [X_W-1:0]    div_x;
	logic [PROD_W-1:0] div_prod;
	logic [DIG_W-1:0]  div_qd;
	logic [X_W-1:0]    div_back;
	logic [REM_W-1:0]  div_rem_n;
	logic [NUM_W-1:0]  iv_clamp;

	logic            out_valid_q;
	logic            accept;
	logic [IV_W-1:0] elapsed_inc;

	assign in_ready = (!out_valid_q || out_ready)
		&& !(div_busy_q && op == tfcg_pkg::OP_BEAT_FIRED);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign elapsed_inc = elapsed_q + IV_W'(1);

	// one digit of the long division: remainder and next digit over the constant divisor
	assign div_x     = {div_rem_q, div_num_q[NUM_W-1 -: DIG_W]};
	assign div_prod  = PROD_W'(div_x) * PROD_W'(RCP);
	assign div_qd    = div_prod[SHIFT +: DIG_W];
	assign div_back  = X_W'(div_qd) * X_W'(PULSES_PER_QUARTER);
	assign div_rem_n = REM_W'(div_x - div_back);

	// clamp the quotient to the minimum, saturate at the timer width, never zero
	always_comb begin
		iv_clamp = div_num_q;
		if (iv_clamp < NUM_W'(min_interval_q))
			iv_clamp = NUM_W'(min_interval_q);
		if (iv_clamp > IV_MAX)
			iv_clamp = IV_MAX;
		if (iv_clamp == '0)
			iv_clamp = NUM_W'(1);
	end

	always_comb begin
		run_d         = run_q;
		last_target_d = last_target_q;
		beat_period_d = beat_period_q;
		armed_d       = armed_q;
		interval_d    = interval_q;
		elapsed_d     = elapsed_q;
		bp_wr         = 1'b0;
		status_d      = 1'b0;
		pulse_d       = 1'b0;
		unique case (op)
			tfcg_pkg::OP_SEND: begin
				if (!link_ready_q || msg_length == '0
						|| msg_length > tfcg_pkg::LEN_W'(tfcg_pkg::MAX_MSG_LEN)) begin
					status_d = 1'b1;
				end else if (msg_length == tfcg_pkg::LEN_W'(1)) begin
					if (status_byte == tfcg_pkg::SB_START
							|| status_byte == tfcg_pkg::SB_CONTINUE) begin
						run_d         = 1'b1;
						last_target_d = '0;
						beat_period_d = '0;
						bp_wr         = 1'b1;
					end else if (status_byte == tfcg_pkg::SB_STOP) begin
						run_d         = 1'b0;
						last_target_d = '0;
						beat_period_d = '0;
						armed_d       = 1'b0;
						interval_d    = '0;
						elapsed_d     = '0;
						bp_wr         = 1'b1;
					end
				end
			end
			tfcg_pkg::OP_BEAT_SCHED: begin
				if (run_q) begin
					if (last_target_q != '0 && time_ms > last_target_q) begin
						beat_period_d = time_ms - last_target_q;
						bp_wr         = 1'b1;
					end
					last_target_d = time_ms;
				end
			end
			tfcg_pkg::OP_BEAT_FIRED: begin
				if (run_q && beat_period_q != '0 && link_ready_q) begin
					interval_d = iv_clamp[IV_W-1:0];
					elapsed_d  = '0;
					armed_d    = 1'b1;
				end
			end
			tfcg_pkg::OP_TICK: begin
				if (armed_q) begin
					if (elapsed_inc >= interval_q) begin
						elapsed_d = '0;
						pulse_d   = link_ready_q;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
			end
			tfcg_pkg::OP_RESET: begin
				run_d         = 1'b0;
				last_target_d = '0;
				beat_period_d = '0;
				armed_d       = 1'b0;
				interval_d    = '0;
				elapsed_d     = '0;
				bp_wr         = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_ready_q   <= 1'b0;
			min_interval_q <= tfcg_pkg::MIN_W'(tfcg_pkg::MIN_INTERVAL_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfcg_pkg::REG_LINK_READY:   link_ready_q   <= cfg_data[0];
				tfcg_pkg::REG_MIN_INTERVAL: min_interval_q <= cfg_data[tfcg_pkg::MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q         <= 1'b0;
			last_target_q <= '0;
			beat_period_q <= '0;
			armed_q       <= 1'b0;
			interval_q    <= '0;
			elapsed_q     <= '0;
		end else if (accept) begin
			run_q         <= run_d;
			last_target_q <= last_target_d;
			beat_period_q <= beat_period_d;
			armed_q       <= armed_d;
			interval_q    <= interval_d;
			elapsed_q     <= elapsed_d;
		end
	end

	// restart the divider on every period update, quotient digits shift in behind the numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_step_q <= '0;
		end else if (accept && bp_wr) begin
			div_busy_q <= beat_period_d != '0;
			div_step_q <= STEP_W'(STEPS - 1);
		end else if (div_busy_q) begin
			if (div_step_q == '0)
				div_busy_q <= 1'b0;
			div_step_q <= div_step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && bp_wr) begin
			div_num_q <= NUM_W'(beat_period_d) * NUM_W'(tfcg_pkg::US_PER_MS);
			div_rem_q <= '0;
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[NUM_W-DIG_W-1:0], div_qd};
			div_rem_q <= div_rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			send_status       <= status_d;
			clock_pulse       <= pulse_d;
			running           <= run_d;
			tempo_period_ms   <= beat_period_d;
			pulse_interval_us <= armed_d ? interval_d : '0;
		end
	end

endmodule
